// ===== design/sacs_pkg.sv =====
package sacs_pkg;

  localparam int TX_BITS  = 8;
  localparam int SAMPLE_W = 12;
  localparam int FUNC_W   = 2;
  localparam int CH_W     = 3;

  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PDOWN  = 2'd2;

  localparam logic [TX_BITS-1:0] CMD_PDOWN = 8'h80;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_PDOWN  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_ACT  = 2'b10
  } seq_st_t;

  typedef struct packed {
    kind_t              kind;
    logic [TX_BITS-1:0] cmd;
    logic               din;
  } qent_t;

  typedef struct packed {
    logic cs_n;
    logic sclk;
    logic dout;
  } pins_t;

endpackage

// ===== design/sacs_chan_if.sv =====
interface sacs_in_if;
  logic                       valid;
  logic                       ready;
  logic [sacs_pkg::FUNC_W-1:0] func;
  logic [sacs_pkg::CH_W-1:0]   channel;
  logic                       unipolar;
  logic                       data_in;

  modport source (output valid, func, channel, unipolar, data_in, input ready);
  modport sink   (input valid, func, channel, unipolar, data_in, output ready);
endinterface

interface sacs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         cs_n;
  logic                         sclk;
  logic                         dout;
  logic                         busy_res;
  logic                         sample_valid;
  logic [sacs_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, cs_n, sclk, dout, busy_res, sample_valid, sample,
                  input ready);
  modport sink   (input valid, cs_n, sclk, dout, busy_res, sample_valid, sample,
                  output ready);
endinterface

// ===== design/sacs_front.sv =====
module sacs_front (
  input  logic              clk,
  input  logic              rst_n,
  sacs_in_if.sink           in_chan,
  output sacs_pkg::qent_t   q_data,
  output logic              q_valid,
  input  logic              q_pop
);

  sacs_pkg::qent_t q_mem_r [2];
  sacs_pkg::qent_t ent;
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;
  logic            pop;

  always_comb begin
    ent.din = in_chan.data_in;
    ent.cmd = sacs_pkg::CMD_PDOWN;
    case (in_chan.func)
      sacs_pkg::FUNC_TICK: begin
        ent.kind = sacs_pkg::KIND_TICK;
      end
      sacs_pkg::FUNC_SAMPLE: begin
        ent.kind = sacs_pkg::KIND_SAMPLE;
        ent.cmd  = {2'b11, in_chan.channel[0], in_chan.channel[2], in_chan.channel[1],
                    in_chan.unipolar, 2'b11};
      end
      sacs_pkg::FUNC_PDOWN: begin
        ent.kind = sacs_pkg::KIND_PDOWN;
      end
      default: begin
        ent.kind = sacs_pkg::KIND_NONE;
      end
    endcase
  end

  assign in_chan.ready = (cnt_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (cnt_r != 2'd0);
  assign pop           = q_pop && q_valid;
  assign q_data        = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= ent;
    end
  end

endmodule

// ===== design/sacs_back.sv =====
module sacs_back #(
  parameter int RX_BITS = 14
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sacs_pkg::qent_t q_data,
  input  logic            q_valid,
  output logic            q_pop,
  sacs_out_if.source      out_chan
);

  localparam int TOTAL = 2 * (sacs_pkg::TX_BITS + RX_BITS);
  localparam int CNT_W = $clog2(TOTAL);

  sacs_pkg::seq_st_t                st_r, st_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [sacs_pkg::TX_BITS-1:0]     cmd_r, cmd_nxt;
  logic [RX_BITS-1:0]               rx_r, rx_nxt;
  logic                             pd_r, pd_nxt;
  sacs_pkg::pins_t                  last_r, last_nxt;
  logic [RX_BITS+1:0]               rx_ext;

  logic                             ov_r;
  sacs_pkg::pins_t                  opins_r, opins_nxt;
  logic                             obusy_r, obusy_nxt;
  logic                             osv_r, osv_nxt;
  logic [sacs_pkg::SAMPLE_W-1:0]    osmp_r, osmp_nxt;

  assign q_pop  = q_valid && (!ov_r || out_chan.ready);
  assign rx_ext = {rx_r, 2'b00};

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    rx_nxt    = rx_r;
    pd_nxt    = pd_r;
    last_nxt  = last_r;
    opins_nxt = '{cs_n: 1'b1, sclk: 1'b0, dout: 1'b0};
    osv_nxt   = 1'b0;
    osmp_nxt  = '0;
    case (st_r)
      sacs_pkg::ST_IDLE: begin
        if (q_data.kind == sacs_pkg::KIND_SAMPLE || q_data.kind == sacs_pkg::KIND_PDOWN) begin
          st_nxt    = sacs_pkg::ST_ACT;
          cnt_nxt   = '0;
          cmd_nxt   = q_data.cmd;
          rx_nxt    = '0;
          pd_nxt    = (q_data.kind == sacs_pkg::KIND_PDOWN);
          last_nxt  = '{cs_n: 1'b0, sclk: 1'b0, dout: 1'b0};
          opins_nxt = '{cs_n: 1'b0, sclk: 1'b0, dout: 1'b0};
        end
      end
      sacs_pkg::ST_ACT: begin
        if (q_data.kind == sacs_pkg::KIND_TICK) begin
          opins_nxt.cs_n = 1'b0;
          opins_nxt.sclk = ~cnt_r[0];
          if (cnt_r < CNT_W'(2 * sacs_pkg::TX_BITS)) begin
            opins_nxt.dout = cmd_r[~cnt_r[3:1]];
          end else begin
            opins_nxt.dout = 1'b0;
            if (!cnt_r[0]) begin
              rx_nxt = {rx_r[RX_BITS-2:0], q_data.din};
            end
          end
          last_nxt = opins_nxt;
          if (cnt_r == CNT_W'(TOTAL - 1)) begin
            st_nxt  = sacs_pkg::ST_IDLE;
            cnt_nxt = '0;
            if (!pd_r) begin
              osv_nxt  = 1'b1;
              osmp_nxt = rx_ext[RX_BITS-1 -: sacs_pkg::SAMPLE_W];
            end
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          opins_nxt = last_r;
        end
      end
      default: begin
        st_nxt = sacs_pkg::ST_IDLE;
      end
    endcase
    obusy_nxt = (st_nxt == sacs_pkg::ST_ACT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= sacs_pkg::ST_IDLE;
      cnt_r  <= '0;
      cmd_r  <= '0;
      rx_r   <= '0;
      pd_r   <= 1'b0;
      last_r <= '{cs_n: 1'b0, sclk: 1'b0, dout: 1'b0};
      ov_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        st_r   <= st_nxt;
        cnt_r  <= cnt_nxt;
        cmd_r  <= cmd_nxt;
        rx_r   <= rx_nxt;
        pd_r   <= pd_nxt;
        last_r <= last_nxt;
        ov_r   <= 1'b1;
      end else if (out_chan.ready) begin
        ov_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      opins_r <= opins_nxt;
      obusy_r <= obusy_nxt;
      osv_r   <= osv_nxt;
      osmp_r  <= osmp_nxt;
    end
  end

  assign out_chan.valid        = ov_r;
  assign out_chan.cs_n         = opins_r.cs_n;
  assign out_chan.sclk         = opins_r.sclk;
  assign out_chan.dout         = opins_r.dout;
  assign out_chan.busy_res     = obusy_r;
  assign out_chan.sample_valid = osv_r;
  assign out_chan.sample       = osmp_r;

endmodule

// ===== design/serial_adc_conversion_sequencer_core.sv =====
// Path: an accepted item is stored in the two-entry queue, then its result goes to the output register.
// Throughput: one item per cycle sustained while out_chan.ready holds; a two-entry queue feeds
// the sequencer, which retires one queued item per cycle into its output register.
// Reset: synchronous, active-low rst_n empties the queue and the output register
// and returns the sequencer to idle with all counters and shift state cleared.
module serial_adc_conversion_sequencer_core #(
  parameter int RX_BITS = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  sacs_in_if.sink    in_chan,
  sacs_out_if.source out_chan
);

  sacs_pkg::qent_t q_data;
  logic            q_valid;
  logic            q_pop;

  sacs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  sacs_back #(
    .RX_BITS (RX_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

`ifndef SYNTH
  a_sample_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.sample_valid |-> !out_chan.busy_res && !out_chan.cs_n)
    else $error("sample result while busy or deselected");

  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.cs_n |-> !out_chan.busy_res && !out_chan.sclk
      && !out_chan.dout && !out_chan.sample_valid)
    else $error("deselected result with active pins");

  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> q_valid)
    else $error("queue refuses items while empty");

  a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule
